// File: src/erod_pkg.sv
// Shared types and constants for the energy ratio onset detector.
// Used by every module under src; depends on nothing.
package erod_pkg;

    localparam int MAX_CHANNELS = 2;
    localparam int MAX_WINDOW   = 4096;
    localparam int INDEX_BITS   = 24;

    localparam int SAMPLE_W  = 16;
    localparam int WLEN_W    = 13;
    localparam int CHAN_W    = 2;
    localparam int RATIO_W   = 8;
    localparam int FLOOR_W   = 30;
    localparam int POS_W     = 12;
    localparam int SQUARE_W  = 31;
    localparam int FRAME_E_W = 32;
    localparam int ENERGY_W  = 44;
    localparam int SCALED_W  = ENERGY_W + RATIO_W;
    localparam int FW_PROD_W = FLOOR_W + WLEN_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    localparam logic [WLEN_W-1:0]     MAX_WINDOW_VAL = WLEN_W'(MAX_WINDOW);
    localparam logic [INDEX_BITS-1:0] INDEX_MAX      = {INDEX_BITS{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_LENGTH = 2'd0,
        REG_CHANNEL_COUNT = 2'd1,
        REG_RATIO_SQUARED = 2'd2,
        REG_MS_FLOOR      = 2'd3
    } erod_reg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] first_sample;
        logic signed [SAMPLE_W-1:0] second_sample;
        logic                       last_frame;
    } erod_in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] onset_frame;
        logic                  onset_found;
    } erod_out_t;

    typedef struct packed {
        logic [WLEN_W-1:0]  window_length;
        logic [CHAN_W-1:0]  channel_count;
        logic [RATIO_W-1:0] ratio_squared;
        logic [FLOOR_W-1:0] mean_square_floor;
    } erod_cfg_t;

endpackage

// File: src/erod_frame_energy.sv
// Frame energy: sum of squared Q15 samples over the configured channels.
// Depends on erod_pkg.
module erod_frame_energy
    import erod_pkg::*;
(
    input  erod_in_t               frame,
    input  erod_cfg_t              cfg,
    output logic [FRAME_E_W-1:0]   frame_energy
);

    logic signed [2*SAMPLE_W-1:0] sq_first;
    logic signed [2*SAMPLE_W-1:0] sq_second;
    logic                         two_channels;

    assign sq_first     = (2*SAMPLE_W)'(frame.first_sample) *
                          (2*SAMPLE_W)'(frame.first_sample);
    assign sq_second    = (2*SAMPLE_W)'(frame.second_sample) *
                          (2*SAMPLE_W)'(frame.second_sample);
    // zero counts as one channel, three saturates to two
    assign two_channels = cfg.channel_count[1];

    always_comb begin
        frame_energy = FRAME_E_W'(sq_first[SQUARE_W-1:0]);
        if (two_channels) begin
            frame_energy = frame_energy + FRAME_E_W'(sq_second[SQUARE_W-1:0]);
        end
    end

endmodule

// File: src/energy_ratio_onset_detector_core.sv
// Top level of the energy ratio onset detector: input stage, window
// accumulation and onset judging, result register. Depends on erod_pkg, erod_frame_energy.
// The result is registered when its last frame is processed out of the input stage.
// Throughput: one frame per cycle; input stalls only while a result waits on m_ready.
// Reset: synchronous, active low; restores config defaults, clears flags and window state.
// State also clears after every last frame.
module energy_ratio_onset_detector_core
    import erod_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  erod_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output erod_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    erod_cfg_t              cfg_reg;

    logic                   in_valid_reg;
    logic [FRAME_E_W-1:0]   in_energy_reg;
    logic                   in_last_reg;
    logic [FRAME_E_W-1:0]   frame_energy;

    logic [ENERGY_W-1:0]    energy_sum_reg,      energy_sum_next;
    logic [ENERGY_W-1:0]    pending_energy_reg,  pending_energy_next;
    logic                   pending_valid_reg,   pending_valid_next;
    logic [ENERGY_W-1:0]    previous_energy_reg, previous_energy_next;
    logic [POS_W-1:0]       window_pos_reg,      window_pos_next;
    logic [INDEX_BITS-1:0]  frame_count_reg,     frame_count_next;
    logic [INDEX_BITS-1:0]  pending_start_reg,   pending_start_next;
    logic [INDEX_BITS-1:0]  found_index_reg,     found_index_next;
    logic                   found_reg,           found_next;
    logic [ENERGY_W-1:0]    limit_reg,           limit_next;
    logic [SCALED_W-1:0]    scaled_reg,          scaled_next;

    logic                   out_valid_reg;
    erod_out_t              out_reg;
    erod_out_t              out_next;

    logic                   process;
    logic                   prev_update;
    logic                   qualify;
    logic                   clear;
    logic [WLEN_W-1:0]      w_eff;
    logic [WLEN_W-1:0]      pos_inc;
    logic [ENERGY_W-1:0]    sum;
    logic [FW_PROD_W-1:0]   floor_window;
    logic [SCALED_W-1:0]    prod_pending;
    logic [SCALED_W-1:0]    prod_previous;

    erod_frame_energy u_frame_energy (
        .frame        (s_data),
        .cfg          (cfg_reg),
        .frame_energy (frame_energy)
    );

    assign process   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || process;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign w_eff = (cfg_reg.window_length > MAX_WINDOW_VAL) ? MAX_WINDOW_VAL
                                                            : cfg_reg.window_length;

    assign floor_window  = FW_PROD_W'(cfg_reg.mean_square_floor) * FW_PROD_W'(w_eff);
    assign limit_next    = cfg_reg.channel_count[1] ? {floor_window, 1'b0}
                                                    : {1'b0, floor_window};
    assign prod_pending  = SCALED_W'(cfg_reg.ratio_squared) * SCALED_W'(pending_energy_reg);
    assign prod_previous = SCALED_W'(cfg_reg.ratio_squared) * SCALED_W'(previous_energy_reg);

    always_comb begin
        energy_sum_next      = energy_sum_reg;
        pending_energy_next  = pending_energy_reg;
        pending_valid_next   = pending_valid_reg;
        previous_energy_next = previous_energy_reg;
        window_pos_next      = window_pos_reg;
        frame_count_next     = frame_count_reg;
        pending_start_next   = pending_start_reg;
        found_index_next     = found_index_reg;
        found_next           = found_reg;
        out_next             = out_reg;
        prev_update          = 1'b0;
        qualify              = 1'b0;
        clear                = 1'b0;
        sum                  = energy_sum_reg + ENERGY_W'(in_energy_reg);
        pos_inc              = WLEN_W'(window_pos_reg) + WLEN_W'(1);

        if (process) begin
            // judge the window completed by the previous frame
            if (pending_valid_reg && !found_reg) begin
                qualify = (previous_energy_reg > limit_reg) &&
                          (SCALED_W'(pending_energy_reg) > scaled_reg);
                if (qualify) begin
                    found_next       = 1'b1;
                    found_index_next = pending_start_reg;
                end else begin
                    previous_energy_next = pending_energy_reg;
                    prev_update          = 1'b1;
                end
            end
            pending_valid_next = 1'b0;

            if (w_eff != '0 && frame_count_reg != INDEX_MAX) begin
                if (window_pos_reg == '0) begin
                    pending_start_next = frame_count_reg;
                end
                if (pos_inc >= w_eff) begin
                    if (!found_next) begin
                        pending_energy_next = sum;
                        pending_valid_next  = 1'b1;
                    end
                    energy_sum_next = '0;
                    window_pos_next = '0;
                end else begin
                    energy_sum_next = sum;
                    window_pos_next = pos_inc[POS_W-1:0];
                end
                frame_count_next = frame_count_reg + INDEX_BITS'(1);
            end

            if (in_last_reg) begin
                out_next.onset_found = found_next;
                out_next.onset_frame = found_next ? found_index_next : '0;
                clear                = 1'b1;
                energy_sum_next      = '0;
                pending_energy_next  = '0;
                pending_valid_next   = 1'b0;
                previous_energy_next = '0;
                window_pos_next      = '0;
                frame_count_next     = '0;
                pending_start_next   = '0;
                found_index_next     = '0;
                found_next           = 1'b0;
            end
        end

        if (clear) begin
            scaled_next = '0;
        end else if (prev_update) begin
            scaled_next = prod_pending;
        end else begin
            scaled_next = prod_previous;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_length     <= WLEN_W'(240);
            cfg_reg.channel_count     <= CHAN_W'(2);
            cfg_reg.ratio_squared     <= RATIO_W'(9);
            cfg_reg.mean_square_floor <= FLOOR_W'(1074);
        end else if (cfg_valid && cfg_ready) begin
            case (erod_reg_idx_t'(cfg_index))
                REG_WINDOW_LENGTH: cfg_reg.window_length     <= cfg_data[WLEN_W-1:0];
                REG_CHANNEL_COUNT: cfg_reg.channel_count     <= cfg_data[CHAN_W-1:0];
                REG_RATIO_SQUARED: cfg_reg.ratio_squared     <= cfg_data[RATIO_W-1:0];
                REG_MS_FLOOR:      cfg_reg.mean_square_floor <= cfg_data[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_energy_reg <= frame_energy;
            in_last_reg   <= s_data.last_frame;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            energy_sum_reg      <= '0;
            pending_energy_reg  <= '0;
            pending_valid_reg   <= 1'b0;
            previous_energy_reg <= '0;
            window_pos_reg      <= '0;
            frame_count_reg     <= '0;
            pending_start_reg   <= '0;
            found_index_reg     <= '0;
            found_reg           <= 1'b0;
            scaled_reg          <= '0;
        end else begin
            energy_sum_reg      <= energy_sum_next;
            pending_energy_reg  <= pending_energy_next;
            pending_valid_reg   <= pending_valid_next;
            previous_energy_reg <= previous_energy_next;
            window_pos_reg      <= window_pos_next;
            frame_count_reg     <= frame_count_next;
            pending_start_reg   <= pending_start_next;
            found_index_reg     <= found_index_next;
            found_reg           <= found_next;
            scaled_reg          <= scaled_next;
        end
        limit_reg <= limit_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (process && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (process && in_last_reg) begin
            out_reg <= out_next;
        end
    end

    a_found_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg && !(process && in_last_reg) |=> found_reg)
        else $error("onset flag dropped mid-buffer");

    a_no_pending_after_found: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_valid_reg |-> !found_reg)
        else $error("window pending after onset found");

    a_window_start_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        window_pos_reg == '0 |-> energy_sum_reg == '0)
        else $error("energy carried into a new window");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(process && in_last_reg))
        else $error("result without a last frame");

    a_frame_zero_when_none: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.onset_found |-> out_reg.onset_frame == '0)
        else $error("onset frame set without onset");

endmodule
